[rtl/mts_pkg.sv]
// Shared types, codes and character-class helpers for the markup token scanner.
package mts_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int MAX_RES    = 6;
  localparam int RES_IDX_W  = $clog2(MAX_RES + 1);

  // Token kinds
  localparam logic [3:0] K_IDENT      = 4'd0;
  localparam logic [3:0] K_KEYWORD    = 4'd1;
  localparam logic [3:0] K_OPEN       = 4'd2;
  localparam logic [3:0] K_OPENSLASH  = 4'd3;
  localparam logic [3:0] K_CLOSE      = 4'd4;
  localparam logic [3:0] K_SLASHCLOSE = 4'd5;
  localparam logic [3:0] K_TEXT       = 4'd6;
  localparam logic [3:0] K_LPAREN     = 4'd7;
  localparam logic [3:0] K_RPAREN     = 4'd8;
  localparam logic [3:0] K_LBRACE     = 4'd9;
  localparam logic [3:0] K_RBRACE     = 4'd10;
  localparam logic [3:0] K_ERROR      = 4'd11;
  localparam logic [3:0] K_END        = 4'd12;

  // Error codes
  localparam logic [1:0] E_NONE       = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_WS_OPEN    = 2'd2;

  // Keyword matcher progress
  localparam logic [2:0] KP_DONE = 3'd4;
  localparam logic [2:0] KP_MISS = 3'd5;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic       is_char;
    logic [7:0] lex_char;
    logic [3:0] kind;
    logic [1:0] err_code;
    logic       last_of_run;
  } out_t;

  // One buffered result, last_of_run is added on the way out
  typedef struct packed {
    logic       is_char;
    logic [7:0] lex_char;
    logic [3:0] kind;
    logic [1:0] err_code;
  } res_t;

  function automatic logic [7:0] kw_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h63; // c
      2'd1:    r = 8'h6F; // o
      2'd2:    r = 8'h6D; // m
      default: r = 8'h70; // p
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_track(input logic [2:0] kp, input logic [7:0] c);
    logic [2:0] r;
    if (kp < KP_DONE && c == kw_char(kp[1:0])) r = kp + 3'd1;
    else r = KP_MISS;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic res_t mk_char(input logic [7:0] c);
    res_t r;
    r.is_char  = 1'b1;
    r.lex_char = c;
    r.kind     = K_IDENT;
    r.err_code = E_NONE;
    return r;
  endfunction

  function automatic res_t mk_mark(input logic [3:0] k);
    res_t r;
    r.is_char  = 1'b0;
    r.lex_char = 8'h00;
    r.kind     = k;
    r.err_code = E_NONE;
    return r;
  endfunction

  function automatic res_t mk_err(input logic [1:0] e);
    res_t r;
    r.is_char  = 1'b0;
    r.lex_char = 8'h00;
    r.kind     = K_ERROR;
    r.err_code = e;
    return r;
  endfunction

endpackage

[rtl/markup_token_scanner_top.sv]
// Markup token scanner: byte-in lexer, buffer drains one token piece a cycle unless stalled.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | in        | in_valid/in_stall  | in_data  : ch, is_final
//  out_    | out       | out_valid/out_stall| out_data : is_char, lex_char, kind,
//          |           |                    |            err_code, last_of_run
//
// Each source byte is scanned in the cycle it is accepted; the results it causes
// (zero to six) land in a result buffer and leave it one per cycle while out_stall is low.
// A byte that causes k results occupies the output until all k have left, so the byte
// rate is set by the single output port.
// A new byte is taken in the same cycle the last buffered result leaves.
// Synchronous active-low reset clears the scanner state and empties the buffer.
// out_stall holds the current result steady and back-pressures in_stall.
module markup_token_scanner_top
  import mts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [2:0] {
    M_NORMAL   = 3'd0,
    M_IDENT    = 3'd1,
    M_LT       = 3'd2,
    M_POSTOPEN = 3'd3,
    M_SLASH    = 3'd4,
    M_TEXT     = 3'd5,
    M_ERROR    = 3'd6
  } mode_t;

  localparam logic signed [DEPTH_BITS-1:0] D_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] D_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] D_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

  // Scanner state
  mode_t                        mode_r,  mode_nxt;
  logic signed [DEPTH_BITS-1:0] depth_r, depth_nxt;
  logic [2:0]                   kp_r,    kp_nxt;

  // Result buffer
  res_t                 res_r [MAX_RES];
  res_t                 res_nxt [MAX_RES];
  logic [RES_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [RES_IDX_W-1:0] idx_r;

  logic out_fire, out_last, in_fire;

  assign out_valid = idx_r < cnt_r;
  assign out_last  = idx_r == (cnt_r - 3'd1);
  assign out_fire  = out_valid && !out_stall;
  // Buffer frees up when its final result is taken this cycle
  assign in_stall  = out_valid && !(out_fire && out_last);
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    out_data.is_char     = res_r[idx_r].is_char;
    out_data.lex_char    = res_r[idx_r].lex_char;
    out_data.kind        = res_r[idx_r].kind;
    out_data.err_code    = res_r[idx_r].err_code;
    out_data.last_of_run = out_last;
  end

  // Scan of one byte: leading action by mode, then token start, then end-of-source flush
  always_comb begin
    mode_t                        m;
    logic signed [DEPTH_BITS-1:0] d;
    logic [2:0]                   kp;
    logic [RES_IDX_W-1:0]         n;
    logic                         start;
    logic [7:0]                   c;

    m     = mode_r;
    d     = depth_r;
    kp    = kp_r;
    n     = '0;
    start = 1'b0;
    c     = in_data.ch;
    for (int i = 0; i < MAX_RES; i++) res_nxt[i] = mk_mark(K_IDENT);

    unique case (m)
      M_IDENT: begin
        if (is_alnum(c)) begin
          res_nxt[n] = mk_char(c); n = n + 3'd1;
          kp = kw_track(kp, c);
        end else begin
          res_nxt[n] = mk_mark((kp == KP_DONE) ? K_KEYWORD : K_IDENT); n = n + 3'd1;
          start = 1'b1;
        end
      end
      M_LT: begin
        res_nxt[n] = mk_char(CH_LT); n = n + 3'd1;
        if (c == CH_SLASH) begin
          res_nxt[n] = mk_char(CH_SLASH);    n = n + 3'd1;
          res_nxt[n] = mk_mark(K_OPENSLASH); n = n + 3'd1;
          if (d != D_MIN) d = d - D_ONE;
          m = M_POSTOPEN;
        end else begin
          res_nxt[n] = mk_mark(K_OPEN); n = n + 3'd1;
          if (d != D_MAX) d = d + D_ONE;
          if (is_space(c)) begin
            res_nxt[n] = mk_err(E_WS_OPEN); n = n + 3'd1;
            m = M_ERROR;
          end else begin
            start = 1'b1;
          end
        end
      end
      M_POSTOPEN: begin
        if (is_space(c)) begin
          res_nxt[n] = mk_err(E_WS_OPEN); n = n + 3'd1;
          m = M_ERROR;
        end else begin
          start = 1'b1;
        end
      end
      M_SLASH: begin
        if (c == CH_GT) begin
          res_nxt[n] = mk_char(CH_SLASH);     n = n + 3'd1;
          res_nxt[n] = mk_char(CH_GT);        n = n + 3'd1;
          res_nxt[n] = mk_mark(K_SLASHCLOSE); n = n + 3'd1;
          if (d != D_MIN) d = d - D_ONE;
          m = (d > 0) ? M_TEXT : M_NORMAL;
        end else begin
          res_nxt[n] = mk_err(E_UNEXPECTED); n = n + 3'd1;
          m = M_ERROR;
        end
      end
      M_TEXT: begin
        if (c == CH_LT) begin
          res_nxt[n] = mk_mark(K_TEXT); n = n + 3'd1;
          m = M_LT;
        end else begin
          res_nxt[n] = mk_char(c); n = n + 3'd1;
        end
      end
      M_ERROR: ;
      default: start = 1'b1;
    endcase

    // Byte opens a new token
    if (start) begin
      m = M_NORMAL;
      if (is_space(c)) begin
        m = M_NORMAL;
      end else if (is_alpha(c)) begin
        res_nxt[n] = mk_char(c); n = n + 3'd1;
        kp = kw_track(3'd0, c);
        m  = M_IDENT;
      end else begin
        case (c)
          CH_LT:    m = M_LT;
          CH_SLASH: m = M_SLASH;
          CH_GT: begin
            res_nxt[n] = mk_char(c);       n = n + 3'd1;
            res_nxt[n] = mk_mark(K_CLOSE); n = n + 3'd1;
            m = (d > 0) ? M_TEXT : M_NORMAL;
          end
          CH_LPAREN: begin
            res_nxt[n] = mk_char(c);        n = n + 3'd1;
            res_nxt[n] = mk_mark(K_LPAREN); n = n + 3'd1;
          end
          CH_RPAREN: begin
            res_nxt[n] = mk_char(c);        n = n + 3'd1;
            res_nxt[n] = mk_mark(K_RPAREN); n = n + 3'd1;
          end
          CH_LBRACE: begin
            res_nxt[n] = mk_char(c);        n = n + 3'd1;
            res_nxt[n] = mk_mark(K_LBRACE); n = n + 3'd1;
          end
          CH_RBRACE: begin
            res_nxt[n] = mk_char(c);        n = n + 3'd1;
            res_nxt[n] = mk_mark(K_RBRACE); n = n + 3'd1;
          end
          default: begin
            res_nxt[n] = mk_err(E_UNEXPECTED); n = n + 3'd1;
            m = M_ERROR;
          end
        endcase
      end
    end

    // End of source: flush what is pending, mark the end, back to reset state
    if (in_data.is_final) begin
      unique case (m)
        M_IDENT: begin
          res_nxt[n] = mk_mark((kp == KP_DONE) ? K_KEYWORD : K_IDENT); n = n + 3'd1;
        end
        M_LT: begin
          res_nxt[n] = mk_char(CH_LT);  n = n + 3'd1;
          res_nxt[n] = mk_mark(K_OPEN); n = n + 3'd1;
        end
        M_SLASH: begin
          res_nxt[n] = mk_err(E_UNEXPECTED); n = n + 3'd1;
        end
        M_TEXT: begin
          res_nxt[n] = mk_mark(K_TEXT); n = n + 3'd1;
        end
        default: ;
      endcase
      res_nxt[n] = mk_mark(K_END); n = n + 3'd1;
      m  = M_NORMAL;
      d  = '0;
      kp = '0;
    end

    mode_nxt  = m;
    depth_nxt = d;
    kp_nxt    = kp;
    cnt_nxt   = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NORMAL;
      depth_r <= '0;
      kp_r    <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      depth_r <= depth_nxt;
      kp_r    <= kp_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= '0;
    end else if (out_fire) begin
      idx_r   <= idx_r + 3'd1;
    end
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) res_r[i] <= res_nxt[i];
    end
  end

  // Checks

  // Input only ever waits on a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall raised with empty result buffer");

  // Lexeme characters carry no kind and no error
  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_char) |-> (out_data.kind == K_IDENT && out_data.err_code == E_NONE))
    else $error("character result with kind or error set");

  // Error codes only on error markers
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.err_code != E_NONE) |-> (out_data.kind == K_ERROR && !out_data.is_char))
    else $error("error code outside an error marker");

  // End of source returns the scanner to its reset state
  a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.is_final) |=> (mode_r == M_NORMAL && depth_r == '0 && kp_r == '0))
    else $error("scanner state not cleared after final byte");

  // A final byte always leaves at least its end marker in the buffer
  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.is_final) |=> out_valid)
    else $error("final byte produced no results");

endmodule
